// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the top-level RTL file.
// The synthesis view defines the same macros with empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: invariant");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/i2cadc_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C converter read master: shared package
// Types, register map and reset values used by the interfaces and modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cadc_pkg;

    // Item kinds.
    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DEV_ADDR    = 2'd0;
    localparam logic [1:0] REG_CTRL_BASE   = 2'd1;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [6:0] RST_DEV_ADDR    = 7'h48;
    localparam logic [7:0] RST_CTRL_BASE   = 8'h40;
    localparam logic [7:0] RST_ACK_TIMEOUT = 8'd250;

    // Number of bits in one bus byte.
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // Which byte of the transfer is being sent and acknowledged.
    localparam logic [1:0] BYTE_ADDR_WR = 2'd0;
    localparam logic [1:0] BYTE_CTRL    = 2'd1;
    localparam logic [1:0] BYTE_ADDR_RD = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'd0,
        ST_S_SDA_HI  = 6'd1,
        ST_S_SCL_HI  = 6'd2,
        ST_S_SDA_LO  = 6'd3,
        ST_W_SCL_LO  = 6'd4,
        ST_W_SDA     = 6'd5,
        ST_W_SCL_HI  = 6'd6,
        ST_W_END_SCL = 6'd7,
        ST_W_END_SDA = 6'd8,
        ST_A_SCL_HI  = 6'd9,
        ST_A_WAIT    = 6'd10,
        ST_R_SCL_LO  = 6'd11,
        ST_R_SDA_HI  = 6'd12,
        ST_R_SCL_HI  = 6'd13,
        ST_R_SAMPLE  = 6'd14,
        ST_N_SDA_HI  = 6'd15,
        ST_N_SCL_HI  = 6'd16,
        ST_N_SCL_LO  = 6'd17,
        ST_T_SDA_LO  = 6'd18,
        ST_T_SCL_HI  = 6'd19,
        ST_T_SDA_HI  = 6'd20
    } t_step;

    typedef struct packed {
        logic       kind;
        logic [1:0] channel;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       ack_missing;
    } t_res;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] control_base;
        logic [7:0] ack_timeout;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/i2cadc_intf.sv =====
// ----------------------------------------------------------------------------
// I2C converter read master: channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2cadc_req_if import i2cadc_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2cadc_res_if import i2cadc_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cadc_seq.sv =====
// ----------------------------------------------------------------------------
// I2C converter read master: bus sequencer
// Holds the bus state and advances it by one request or tick per go pulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cadc_seq import i2cadc_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_go,
    input  wire t_req i_item,
    input  wire t_cfg i_cfg,
    output t_res      o_res
);

    t_step      r_step,    n_step;
    logic [3:0] r_bit_idx, n_bit_idx;
    logic [7:0] r_shift,   n_shift;
    logic [7:0] r_wait,    n_wait;
    logic       r_active,  n_active;
    logic       r_nack,    n_nack;
    logic       r_scl,     n_scl;
    logic       r_sda,     n_sda;
    logic [1:0] r_chan,    n_chan;
    logic [1:0] r_byte_no, n_byte_no;
    logic       n_done;
    logic [3:0] bit_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_IDLE;
            r_bit_idx <= '0;
            r_shift   <= '0;
            r_wait    <= '0;
            r_active  <= 1'b0;
            r_nack    <= 1'b0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_chan    <= '0;
            r_byte_no <= BYTE_ADDR_WR;
        end else if (i_go) begin
            r_step    <= n_step;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_wait    <= n_wait;
            r_active  <= n_active;
            r_nack    <= n_nack;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_chan    <= n_chan;
            r_byte_no <= n_byte_no;
        end
    end

    assign bit_inc = r_bit_idx + 4'd1;

    always_comb begin
        n_step    = r_step;
        n_bit_idx = r_bit_idx;
        n_shift   = r_shift;
        n_wait    = r_wait;
        n_active  = r_active;
        n_nack    = r_nack;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_chan    = r_chan;
        n_byte_no = r_byte_no;
        n_done    = 1'b0;

        if (i_item.kind == KIND_REQ) begin
            // A request while a transfer runs is dropped.
            if (!r_active) begin
                n_active  = 1'b1;
                n_chan    = i_item.channel;
                n_byte_no = BYTE_ADDR_WR;
                n_bit_idx = '0;
                n_wait    = '0;
                n_step    = ST_S_SDA_HI;
            end
        end else if (r_active) begin
            unique case (r_step)
                ST_S_SDA_HI: begin
                    n_sda  = 1'b1;
                    n_step = ST_S_SCL_HI;
                end
                ST_S_SCL_HI: begin
                    n_scl  = 1'b1;
                    n_step = ST_S_SDA_LO;
                end
                ST_S_SDA_LO: begin
                    n_sda     = 1'b0;
                    n_shift   = {i_cfg.device_address, r_byte_no != BYTE_ADDR_WR};
                    n_bit_idx = '0;
                    n_step    = ST_W_SCL_LO;
                end
                ST_W_SCL_LO: begin
                    n_scl  = 1'b0;
                    n_step = ST_W_SDA;
                end
                ST_W_SDA: begin
                    n_sda   = r_shift[7];
                    n_shift = {r_shift[6:0], 1'b0};
                    n_step  = ST_W_SCL_HI;
                end
                ST_W_SCL_HI: begin
                    n_scl = 1'b1;
                    if (bit_inc >= BYTE_BITS) begin
                        n_bit_idx = '0;
                        n_step    = ST_W_END_SCL;
                    end else begin
                        n_bit_idx = bit_inc;
                        n_step    = ST_W_SCL_LO;
                    end
                end
                ST_W_END_SCL: begin
                    n_scl  = 1'b0;
                    n_step = ST_W_END_SDA;
                end
                ST_W_END_SDA: begin
                    n_sda  = 1'b1;
                    n_step = ST_A_SCL_HI;
                end
                ST_A_SCL_HI: begin
                    n_scl  = 1'b1;
                    n_wait = '0;
                    n_step = ST_A_WAIT;
                end
                ST_A_WAIT: begin
                    // Hold the clock high until the slave pulls data low or time runs out.
                    if (i_item.sda_in && (r_wait < i_cfg.ack_timeout)) begin
                        n_wait = r_wait + 8'd1;
                    end else begin
                        if (i_item.sda_in) begin
                            n_nack = 1'b1;
                        end
                        n_scl = 1'b0;
                        if (r_byte_no == BYTE_ADDR_WR) begin
                            n_byte_no = BYTE_CTRL;
                            n_shift   = i_cfg.control_base | {6'd0, r_chan};
                            n_step    = ST_W_SCL_LO;
                        end else if (r_byte_no == BYTE_CTRL) begin
                            n_byte_no = BYTE_ADDR_RD;
                            n_step    = ST_S_SDA_HI;
                        end else begin
                            n_step = ST_R_SCL_LO;
                        end
                    end
                end
                ST_R_SCL_LO: begin
                    n_scl  = 1'b0;
                    n_step = ST_R_SDA_HI;
                end
                ST_R_SDA_HI: begin
                    n_sda     = 1'b1;
                    n_bit_idx = '0;
                    n_shift   = '0;
                    n_step    = ST_R_SCL_HI;
                end
                ST_R_SCL_HI: begin
                    n_scl  = 1'b1;
                    n_step = ST_R_SAMPLE;
                end
                ST_R_SAMPLE: begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_scl   = 1'b0;
                    if (bit_inc >= BYTE_BITS) begin
                        n_bit_idx = '0;
                        n_done    = 1'b1;
                        n_step    = ST_N_SDA_HI;
                    end else begin
                        n_bit_idx = bit_inc;
                        n_step    = ST_R_SCL_HI;
                    end
                end
                ST_N_SDA_HI: begin
                    n_sda  = 1'b1;
                    n_step = ST_N_SCL_HI;
                end
                ST_N_SCL_HI: begin
                    n_scl  = 1'b1;
                    n_step = ST_N_SCL_LO;
                end
                ST_N_SCL_LO: begin
                    n_scl  = 1'b0;
                    n_step = ST_T_SDA_LO;
                end
                ST_T_SDA_LO: begin
                    n_sda  = 1'b0;
                    n_step = ST_T_SCL_HI;
                end
                ST_T_SCL_HI: begin
                    n_scl  = 1'b1;
                    n_step = ST_T_SDA_HI;
                end
                ST_T_SDA_HI: begin
                    n_sda    = 1'b1;
                    n_step   = ST_IDLE;
                    n_active = 1'b0;
                end
                default: begin
                    n_step   = ST_IDLE;
                    n_active = 1'b0;
                end
            endcase
        end

        o_res.scl_out     = n_scl;
        o_res.sda_out     = n_sda;
        o_res.busy_res    = n_active;
        o_res.data_valid  = n_done;
        o_res.data_byte   = n_done ? n_shift : 8'd0;
        o_res.ack_missing = n_nack;
    end

endmodule

`default_nettype wire

// ===== rtl/i2c_adc_channel_read_master.sv =====
// A request is taken into the input register; the sequencer output for it is
// then registered in the result register, from which results are offered.
// Throughput: one request per clock unless results stall; sequencer state is the only loop.
// Reset (synchronous, active low): idle, both bus lines released, missing-ack
// flag cleared, registers back to address 0x48, control 0x40, timeout 250.
// ----------------------------------------------------------------------------
// I2C converter read master: top level
// Request and result channels, register port, and the two pipeline registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module i2c_adc_channel_read_master import i2cadc_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    i2cadc_req_if.sink             i_req,
    i2cadc_res_if.source           o_res,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [APB_ADDR_W-1:0]   paddr,
    input  wire [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    t_cfg r_cfg;
    t_req r_in;
    logic r_in_vld;
    t_res r_out;
    logic r_out_vld;
    t_res seq_res;
    logic s2_go;
    logic in_fire;
    logic cfg_wr;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= RST_DEV_ADDR;
            r_cfg.control_base   <= RST_CTRL_BASE;
            r_cfg.ack_timeout    <= RST_ACK_TIMEOUT;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DEV_ADDR:    r_cfg.device_address <= pwdata[6:0];
                REG_CTRL_BASE:   r_cfg.control_base   <= pwdata[7:0];
                REG_ACK_TIMEOUT: r_cfg.ack_timeout    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DEV_ADDR:    prdata = {25'd0, r_cfg.device_address};
            REG_CTRL_BASE:   prdata = {24'd0, r_cfg.control_base};
            REG_ACK_TIMEOUT: prdata = {24'd0, r_cfg.ack_timeout};
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    // The sequencer advances whenever a request is held and the result register can take its output.
    assign s2_go       = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || s2_go;
    assign in_fire     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_fire) begin
            r_in_vld <= 1'b1;
        end else if (s2_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_req.data;
        end
    end

    i2cadc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (s2_go),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_go) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    // ---------------- checks ----------------
    // With no transfer running, both bus lines are released.
    `ASSERT_ALWAYS(a_idle_lines, i_clk, i_rst_n, !r_out_vld || r_out.busy_res || (r_out.scl_out && r_out.sda_out))
    // A completed byte is only reported inside a transfer.
    `ASSERT_ALWAYS(a_valid_busy, i_clk, i_rst_n, !(r_out_vld && r_out.data_valid) || r_out.busy_res)
    // Once a missing acknowledge is reported, later results keep the flag.
    `ASSERT_NEXT(a_nack_sticky, i_clk, i_rst_n, r_out_vld && r_out.ack_missing, r_out.ack_missing)
    // A held request is not dropped while the result side stalls.
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_vld && !s2_go, r_in_vld && $stable(r_in))

endmodule

`default_nettype wire

// ===== dv/tb_i2c_adc_channel_read_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C converter read master: testbench
// Drives requests and half-phase ticks into the read master and checks every
// result against fixed line levels or a cycle-free predictor of the sequencer,
// over several register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module tb_i2c_adc_channel_read_master import i2cadc_pkg::*; ();

    localparam int CYCLE_LIMIT    = 500000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int N_PHASES       = 5;

    typedef struct packed {
        logic       kind;
        logic [1:0] channel;
        logic       sda_in;
        logic       typed;
        t_res       want;
    } t_dir_row;

    typedef struct packed {
        logic        rand_cfg;
        logic [6:0]  dev;
        logic [7:0]  base;
        logic [7:0]  tmo;
        logic [10:0] n_items;
        logic [6:0]  hi_pct;
        logic        gaps;
    } t_phase;

    // Line levels that can be read straight off the sequence.
    localparam t_res LINES_IDLE  = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
    localparam t_res LINES_ARMED = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
    localparam t_res NO_LINES    = '0;

    localparam int N_DIRECTED = 20;
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        '{KIND_TICK, 2'd0, 1'b0, 1'b1, LINES_IDLE},
        '{KIND_TICK, 2'd3, 1'b1, 1'b1, LINES_IDLE},
        '{KIND_REQ,  2'd3, 1'b0, 1'b1, LINES_ARMED},
        '{KIND_REQ,  2'd0, 1'b1, 1'b1, LINES_ARMED},
        '{KIND_TICK, 2'd1, 1'b1, 1'b1, LINES_ARMED},
        '{KIND_TICK, 2'd2, 1'b0, 1'b1, LINES_ARMED},
        '{KIND_TICK, 2'd0, 1'b1, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd3, 1'b0, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd1, 1'b1, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd2, 1'b0, 1'b0, NO_LINES},
        '{KIND_REQ,  2'd1, 1'b0, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd0, 1'b1, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd3, 1'b1, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd0, 1'b0, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd2, 1'b0, 1'b0, NO_LINES},
        '{KIND_REQ,  2'd2, 1'b1, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd1, 1'b0, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd3, 1'b1, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd0, 1'b0, 1'b0, NO_LINES},
        '{KIND_TICK, 2'd2, 1'b1, 1'b0, NO_LINES}
    };

    // Register setting, length and acknowledge behavior of each random phase.
    localparam t_phase PHASES [N_PHASES] = '{
        '{1'b0, RST_DEV_ADDR, RST_CTRL_BASE, RST_ACK_TIMEOUT, 11'd220, 7'd40, 1'b1},
        '{1'b0, 7'd127, 8'd255, 8'd255, 11'd220, 7'd60, 1'b1},
        '{1'b0, 7'd0,   8'd0,   8'd1,   11'd200, 7'd50, 1'b1},
        '{1'b0, 7'h55,  8'hAA,  8'd0,   11'd160, 7'd50, 1'b1},
        '{1'b1, 7'd0,   8'd0,   8'd0,   11'd200, 7'd70, 1'b0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    i2cadc_req_if req_ch ();
    i2cadc_res_if res_ch ();

    i2c_adc_channel_read_master dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted state of the bus sequencer and its registers.
    t_cfg       cfg_q;
    t_step      bus_step;
    logic [3:0] bit_cnt;
    logic [7:0] shifter;
    logic [7:0] ack_wait;
    logic       bus_busy;
    logic       ack_lost;
    logic       scl_lvl;
    logic       sda_lvl;
    logic [1:0] chan_q;
    logic [1:0] cur_byte;

    t_res pending_lines[$];
    int   mismatches = 0;
    int   cycle_cnt  = 0;
    logic gaps_on    = 1'b1;
    logic hold_rx    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_res predict_lines(t_req it);
        t_res r;
        logic got_byte;
        got_byte = 1'b0;
        if (it.kind == KIND_REQ) begin
            if (!bus_busy) begin
                bus_busy = 1'b1;
                chan_q   = it.channel;
                cur_byte = BYTE_ADDR_WR;
                bit_cnt  = '0;
                ack_wait = '0;
                bus_step = ST_S_SDA_HI;
            end
        end else if (bus_busy) begin
            case (bus_step)
                ST_S_SDA_HI: begin
                    sda_lvl  = 1'b1;
                    bus_step = ST_S_SCL_HI;
                end
                ST_S_SCL_HI: begin
                    scl_lvl  = 1'b1;
                    bus_step = ST_S_SDA_LO;
                end
                ST_S_SDA_LO: begin
                    sda_lvl  = 1'b0;
                    shifter  = {cfg_q.device_address, cur_byte != BYTE_ADDR_WR};
                    bit_cnt  = '0;
                    bus_step = ST_W_SCL_LO;
                end
                ST_W_SCL_LO: begin
                    scl_lvl  = 1'b0;
                    bus_step = ST_W_SDA;
                end
                ST_W_SDA: begin
                    sda_lvl  = shifter[7];
                    shifter  = shifter << 1;
                    bus_step = ST_W_SCL_HI;
                end
                ST_W_SCL_HI: begin
                    scl_lvl = 1'b1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= BYTE_BITS) begin
                        bit_cnt  = '0;
                        bus_step = ST_W_END_SCL;
                    end else begin
                        bus_step = ST_W_SCL_LO;
                    end
                end
                ST_W_END_SCL: begin
                    scl_lvl  = 1'b0;
                    bus_step = ST_W_END_SDA;
                end
                ST_W_END_SDA: begin
                    sda_lvl  = 1'b1;
                    bus_step = ST_A_SCL_HI;
                end
                ST_A_SCL_HI: begin
                    scl_lvl  = 1'b1;
                    ack_wait = '0;
                    bus_step = ST_A_WAIT;
                end
                ST_A_WAIT: begin
                    // A high data line keeps the clock up until the timeout count is used.
                    if (it.sda_in && ack_wait < cfg_q.ack_timeout) begin
                        ack_wait = ack_wait + 8'd1;
                    end else begin
                        if (it.sda_in) ack_lost = 1'b1;
                        scl_lvl = 1'b0;
                        if (cur_byte == BYTE_ADDR_WR) begin
                            cur_byte = BYTE_CTRL;
                            shifter  = cfg_q.control_base | {6'd0, chan_q};
                            bus_step = ST_W_SCL_LO;
                        end else if (cur_byte == BYTE_CTRL) begin
                            cur_byte = BYTE_ADDR_RD;
                            bus_step = ST_S_SDA_HI;
                        end else begin
                            bus_step = ST_R_SCL_LO;
                        end
                    end
                end
                ST_R_SCL_LO: begin
                    scl_lvl  = 1'b0;
                    bus_step = ST_R_SDA_HI;
                end
                ST_R_SDA_HI: begin
                    sda_lvl  = 1'b1;
                    bit_cnt  = '0;
                    shifter  = '0;
                    bus_step = ST_R_SCL_HI;
                end
                ST_R_SCL_HI: begin
                    scl_lvl  = 1'b1;
                    bus_step = ST_R_SAMPLE;
                end
                ST_R_SAMPLE: begin
                    shifter = {shifter[6:0], it.sda_in};
                    scl_lvl = 1'b0;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= BYTE_BITS) begin
                        bit_cnt  = '0;
                        got_byte = 1'b1;
                        bus_step = ST_N_SDA_HI;
                    end else begin
                        bus_step = ST_R_SCL_HI;
                    end
                end
                ST_N_SDA_HI: begin
                    sda_lvl  = 1'b1;
                    bus_step = ST_N_SCL_HI;
                end
                ST_N_SCL_HI: begin
                    scl_lvl  = 1'b1;
                    bus_step = ST_N_SCL_LO;
                end
                ST_N_SCL_LO: begin
                    scl_lvl  = 1'b0;
                    bus_step = ST_T_SDA_LO;
                end
                ST_T_SDA_LO: begin
                    sda_lvl  = 1'b0;
                    bus_step = ST_T_SCL_HI;
                end
                ST_T_SCL_HI: begin
                    scl_lvl  = 1'b1;
                    bus_step = ST_T_SDA_HI;
                end
                ST_T_SDA_HI: begin
                    sda_lvl  = 1'b1;
                    bus_step = ST_IDLE;
                    bus_busy = 1'b0;
                end
                default: begin
                    bus_step = ST_IDLE;
                    bus_busy = 1'b0;
                end
            endcase
        end
        r.scl_out     = scl_lvl;
        r.sda_out     = sda_lvl;
        r.busy_res    = bus_busy;
        r.data_valid  = got_byte;
        r.data_byte   = got_byte ? shifter : 8'h00;
        r.ack_missing = ack_lost;
        return r;
    endfunction

    function automatic void check_field(string tag, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, tag, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: %h", $time, res_ch.data);
            end else begin
                want = pending_lines.pop_front();
                check_field("scl_out",     8'(want.scl_out),     8'(res_ch.data.scl_out));
                check_field("sda_out",     8'(want.sda_out),     8'(res_ch.data.sda_out));
                check_field("busy_res",    8'(want.busy_res),    8'(res_ch.data.busy_res));
                check_field("data_valid",  8'(want.data_valid),  8'(res_ch.data.data_valid));
                check_field("data_byte",   want.data_byte,       res_ch.data.data_byte);
                check_field("ack_missing", 8'(want.ack_missing), 8'(res_ch.data.ack_missing));
            end
        end
    end

    // Result side: short random stalls, plus one long hold-off on demand.
    initial begin
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                res_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
                res_ch.ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic offer_request(t_req it, t_res want);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        pending_lines.push_back(want);
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain_lines();
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        t_req        it;
        t_res        lines;
        int unsigned n;

        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;

        cfg_q    = '{RST_DEV_ADDR, RST_CTRL_BASE, RST_ACK_TIMEOUT};
        bus_step = ST_IDLE;
        bit_cnt  = '0;
        shifter  = '0;
        ack_wait = '0;
        bus_busy = 1'b0;
        ack_lost = 1'b0;
        scl_lvl  = 1'b1;
        sda_lvl  = 1'b1;
        chan_q   = '0;
        cur_byte = BYTE_ADDR_WR;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            it.kind    = DIRECTED[i].kind;
            it.channel = DIRECTED[i].channel;
            it.sda_in  = DIRECTED[i].sda_in;
            lines = predict_lines(it);
            offer_request(it, DIRECTED[i].typed ? DIRECTED[i].want : lines);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            req_ch.valid <= 1'b0;
            drain_lines();
            if (p != 0) begin
                if (PHASES[p].rand_cfg) begin
                    cfg_q.device_address = 7'($urandom_range(1, 126));
                    cfg_q.control_base   = 8'($urandom_range(0, 255));
                    cfg_q.ack_timeout    = 8'($urandom_range(2, 8));
                end else begin
                    cfg_q = '{PHASES[p].dev, PHASES[p].base, PHASES[p].tmo};
                end
                write_reg(REG_DEV_ADDR,    APB_DATA_W'(cfg_q.device_address));
                write_reg(REG_CTRL_BASE,   APB_DATA_W'(cfg_q.control_base));
                write_reg(REG_ACK_TIMEOUT, APB_DATA_W'(cfg_q.ack_timeout));
            end
            gaps_on = PHASES[p].gaps;
            n = 0;
            // Each phase ends on an idle sequencer so the next register write is safe.
            while (n < PHASES[p].n_items || bus_busy) begin
                if (p == 0 && n == 60) hold_rx = 1'b1;
                if (p == 0 && n == 150) begin
                    req_ch.valid <= 1'b0;
                    drain_lines();
                end
                it.kind    = KIND_TICK;
                it.channel = 2'($urandom_range(0, 3));
                it.sda_in  = 1'($urandom_range(0, 1));
                if (!bus_busy) begin
                    if ($urandom_range(0, 9) < 8) it.kind = KIND_REQ;
                end else if ($urandom_range(0, 49) == 0) begin
                    // A request in the middle of a read must be ignored.
                    it.kind = KIND_REQ;
                end else if (bus_step == ST_A_WAIT) begin
                    it.sda_in = ($urandom_range(0, 99) < PHASES[p].hi_pct);
                end
                offer_request(it, predict_lines(it));
                n++;
            end
        end

        req_ch.valid <= 1'b0;
        drain_lines();
        if (mismatches == 0 && pending_lines.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
